// ===== rtl/core/wdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Window distinct count package
// Shared constants, command codes, state encoding and control structs.
// ----------------------------------------------------------------------------
package wdc_pkg;

    localparam int MAX_LENGTH  = 1024;
    localparam int VALUE_BITS  = 10;
    localparam int VALUE_DEPTH = 1 << VALUE_BITS;
    localparam int ADDR_W      = $clog2(MAX_LENGTH);
    localparam int POS_W       = 11;
    localparam int CNT_W       = 11;
    localparam int CMD_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_code;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CHECK,
        ST_STEP,
        ST_CNT,
        ST_UPD,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic clr_wr;
        logic step;
        logic cnt_rd;
        logic upd;
        logic result;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_query;
        logic stale;
        logic clr_last;
        logic bad;
        logic step_done;
        logic out_free;
    } t_ctrl_sts;

endpackage

// ===== rtl/core/wdc_if.sv =====
// ----------------------------------------------------------------------------
// Window distinct count channels
// Valid/ready channels for items, results and the length register write.
// ----------------------------------------------------------------------------
interface wdc_in_if;
    import wdc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      command;
    logic [VALUE_BITS-1:0] element_value;
    logic [POS_W-1:0]      prefix_end;
    logic [POS_W-1:0]      suffix_start;
    modport source (output valid, command, element_value, prefix_end, suffix_start,
                    input ready);
    modport sink (input valid, command, element_value, prefix_end, suffix_start,
                  output ready);
endinterface

interface wdc_out_if;
    import wdc_pkg::*;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] distinct_count;
    logic             bad_query;
    modport source (output valid, distinct_count, bad_query, input ready);
    modport sink (input valid, distinct_count, bad_query, output ready);
endinterface

interface wdc_cfg_if;
    import wdc_pkg::*;
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] seq_length;
    modport source (output valid, seq_length, input ready);
    modport sink (input valid, seq_length, output ready);
endinterface

// ===== rtl/core/wdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Window distinct count controller
// Sequences item intake, count table clearing, window steps and results.
// ----------------------------------------------------------------------------
module wdc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wdc_pkg::t_ctrl_sts  i_sts,
    output wdc_pkg::t_ctrl_cmd  o_cmd
);
    import wdc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_sts.stale) begin
                    n_state = ST_CLEAR;
                end else begin
                    o_cmd.in_ready = 1'b1;
                    if (i_sts.in_valid && i_sts.in_query) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CHECK: begin
                n_state = i_sts.bad ? ST_RESULT : ST_STEP;
            end
            ST_STEP: begin
                if (i_sts.step_done) begin
                    n_state = ST_RESULT;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_CNT;
                end
            end
            ST_CNT: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_STEP;
            end
            ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/wdc_datapath.sv =====
// ----------------------------------------------------------------------------
// Window distinct count datapath
// Sequence store, value count table, window ends, total and result register.
// ----------------------------------------------------------------------------
module wdc_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    wdc_in_if.sink             i_in,
    wdc_out_if.source          o_out,
    wdc_cfg_if.sink            i_cfg,
    input  wdc_pkg::t_ctrl_cmd i_cmd,
    output wdc_pkg::t_ctrl_sts o_sts
);
    import wdc_pkg::*;

    logic [VALUE_BITS-1:0] m_store [MAX_LENGTH];
    logic [CNT_W-1:0]      m_count [VALUE_DEPTH];

    logic [POS_W-1:0]      r_seq_len, n_seq_len;
    logic [POS_W-1:0]      r_load_ptr, n_load_ptr;
    logic [POS_W-1:0]      r_left, n_left;
    logic [POS_W-1:0]      r_right, n_right;
    logic [CNT_W-1:0]      r_total, n_total;
    logic [POS_W-1:0]      r_lo, n_lo;
    logic [POS_W-1:0]      r_hi, n_hi;
    logic                  r_bad, n_bad;
    logic                  r_stale, n_stale;
    logic                  r_used, n_used;
    logic [VALUE_BITS-1:0] r_clr_addr, n_clr_addr;
    logic                  r_enter, n_enter;
    logic                  r_out_valid, n_out_valid;
    logic [CNT_W-1:0]      r_out_count, n_out_count;
    logic                  r_out_bad, n_out_bad;
    logic [VALUE_BITS-1:0] r_store_q;
    logic [VALUE_BITS-1:0] r_val;
    logic [CNT_W-1:0]      r_count_q;

    logic                  in_fire;
    logic                  cfg_fire;
    logic [POS_W-1:0]      len_eff;
    logic [POS_W:0]        hi_sum;
    logic                  grow_right;
    logic                  grow_left;
    logic                  shrink_left;
    logic                  shrink_right;
    logic [POS_W-1:0]      step_pos;
    logic [POS_W-1:0]      pos_m1;
    logic [POS_W-1:0]      idx_full;
    logic [ADDR_W-1:0]     store_ra;
    logic                  store_we;
    logic                  cnt_we;
    logic [VALUE_BITS-1:0] cnt_wa;
    logic [CNT_W-1:0]      cnt_wd;

    assign in_fire  = i_in.valid && i_cmd.in_ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    assign i_in.ready  = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid          = r_out_valid;
    assign o_out.distinct_count = r_out_count;
    assign o_out.bad_query      = r_out_bad;

    assign len_eff = (r_seq_len > POS_W'(MAX_LENGTH)) ? POS_W'(MAX_LENGTH) : r_seq_len;
    assign hi_sum  = {1'b0, i_in.prefix_end} + {1'b0, len_eff};

    assign grow_right   = r_right < r_hi;
    assign grow_left    = r_left > r_lo;
    assign shrink_left  = r_left < r_lo;
    assign shrink_right = r_right > r_hi;

    always_comb begin
        priority if (grow_right) begin
            step_pos = r_right + POS_W'(1);
        end else if (grow_left) begin
            step_pos = r_left - POS_W'(1);
        end else if (shrink_left) begin
            step_pos = r_left;
        end else begin
            step_pos = r_right;
        end
    end

    assign pos_m1   = step_pos - POS_W'(1);
    assign idx_full = (pos_m1 >= len_eff) ? pos_m1 - len_eff : pos_m1;
    assign store_ra = idx_full[ADDR_W-1:0];

    assign o_sts.in_valid  = i_in.valid;
    assign o_sts.in_query  = (i_in.command == CMD_QUERY);
    assign o_sts.stale     = r_stale;
    assign o_sts.clr_last  = (r_clr_addr == '1);
    assign o_sts.bad       = r_bad;
    assign o_sts.step_done = !(grow_right || grow_left || shrink_left || shrink_right);
    assign o_sts.out_free  = !r_out_valid || o_out.ready;

    assign store_we = in_fire && (i_in.command == CMD_LOAD)
                      && (r_load_ptr != POS_W'(MAX_LENGTH));

    always_comb begin
        cnt_we = 1'b0;
        cnt_wa = r_val;
        cnt_wd = r_count_q;
        if (i_cmd.clr_wr) begin
            cnt_we = 1'b1;
            cnt_wa = r_clr_addr;
            cnt_wd = '0;
        end else if (i_cmd.upd) begin
            if (r_enter) begin
                cnt_we = 1'b1;
                cnt_wd = r_count_q + CNT_W'(1);
            end else if (r_count_q != '0) begin
                cnt_we = 1'b1;
                cnt_wd = r_count_q - CNT_W'(1);
            end
        end
    end

    always_comb begin
        logic empty_req;
        empty_req   = 1'b0;
        n_seq_len   = r_seq_len;
        n_load_ptr  = r_load_ptr;
        n_left      = r_left;
        n_right     = r_right;
        n_total     = r_total;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_bad       = r_bad;
        n_stale     = r_stale;
        n_used      = r_used;
        n_clr_addr  = r_clr_addr;
        n_enter     = r_enter;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_bad   = r_out_bad;

        if (cfg_fire) begin
            n_seq_len = i_cfg.seq_length;
            empty_req = 1'b1;
        end

        if (in_fire) begin
            unique case (i_in.command)
                CMD_LOAD: begin
                    empty_req = 1'b1;
                    if (r_load_ptr != POS_W'(MAX_LENGTH)) begin
                        n_load_ptr = r_load_ptr + POS_W'(1);
                    end
                end
                CMD_CLEAR: begin
                    empty_req  = 1'b1;
                    n_load_ptr = '0;
                end
                CMD_QUERY: begin
                    n_lo  = i_in.suffix_start;
                    n_hi  = hi_sum[POS_W-1:0];
                    n_bad = (len_eff == '0) || (i_in.prefix_end == '0)
                            || (i_in.suffix_start > len_eff)
                            || (i_in.prefix_end >= i_in.suffix_start);
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.step) begin
            n_enter = grow_right || grow_left;
            priority if (grow_right) begin
                n_right = r_right + POS_W'(1);
            end else if (grow_left) begin
                n_left = r_left - POS_W'(1);
            end else if (shrink_left) begin
                n_left = r_left + POS_W'(1);
            end else begin
                n_right = r_right - POS_W'(1);
            end
        end

        if (i_cmd.upd) begin
            n_used = 1'b1;
            if (r_enter) begin
                if (r_count_q == '0) begin
                    n_total = r_total + CNT_W'(1);
                end
            end else if (r_count_q == CNT_W'(1)) begin
                n_total = r_total - CNT_W'(1);
            end
        end

        if (empty_req) begin
            n_left  = POS_W'(1);
            n_right = '0;
            n_total = '0;
            n_stale = r_stale || r_used;
        end

        if (i_cmd.clr_wr) begin
            n_clr_addr = r_clr_addr + VALUE_BITS'(1);
            if (r_clr_addr == '1) begin
                n_stale = 1'b0;
                n_used  = 1'b0;
            end
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.result) begin
            n_out_valid = 1'b1;
            n_out_count = r_bad ? '0 : r_total;
            n_out_bad   = r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len   <= POS_W'(1);
            r_load_ptr  <= '0;
            r_left      <= POS_W'(1);
            r_right     <= '0;
            r_total     <= '0;
            r_stale     <= 1'b1;
            r_used      <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq_len   <= n_seq_len;
            r_load_ptr  <= n_load_ptr;
            r_left      <= n_left;
            r_right     <= n_right;
            r_total     <= n_total;
            r_stale     <= n_stale;
            r_used      <= n_used;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_bad       <= n_bad;
        r_enter     <= n_enter;
        r_out_count <= n_out_count;
        r_out_bad   <= n_out_bad;
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            m_store[r_load_ptr[ADDR_W-1:0]] <= i_in.element_value;
        end
        if (i_cmd.step) begin
            r_store_q <= m_store[store_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_count[cnt_wa] <= cnt_wd;
        end
        if (i_cmd.cnt_rd) begin
            r_count_q <= m_count[r_store_q];
            r_val     <= r_store_q;
        end
    end

endmodule

// ===== rtl/core/window_distinct_count_engine.sv =====
// ----------------------------------------------------------------------------
// Window distinct count engine
// Counts distinct values over a circular window of a loaded sequence.
// ----------------------------------------------------------------------------
// A rejected query goes from the check state to the result state; a valid one first
// makes window end steps, each through the step, count read and update states, up
// to about three times the length in use from an empty window. One item is in work
// at a time. Synchronous active-low reset; after reset, and after a load, clear or
// length write that follows a window move, a pass over every count table entry
// clears the table while no item transfer is taken.
// ----------------------------------------------------------------------------
module window_distinct_count_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wdc_in_if.sink    i_in,
    wdc_out_if.source o_out,
    wdc_cfg_if.sink   i_cfg
);
    import wdc_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_ctrl_sts ctrl_sts;

    wdc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (ctrl_sts),
        .o_cmd   (ctrl_cmd)
    );

    wdc_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (ctrl_cmd),
        .o_sts   (ctrl_sts)
    );

endmodule

// ===== tb/sv/tb_window_distinct_count_engine.sv =====
// ----------------------------------------------------------------------------
// Window distinct count engine testbench
// Loads sequences, writes the length register and sends queries through the
// item channel, and predicts every answer with an independent window tally.
// Each answer is compared field by field, in order, with the prediction.
// Random gaps on both channels, one long hold on the result channel and
// drained pauses between register writes exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_window_distinct_count_engine;
    import wdc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned RESULT_HOLD_CYCLES = 400;
    localparam int unsigned LONG_HOLD_AT = 60;
    localparam int unsigned RANDOM_ITEMS = 380;
    localparam int unsigned FILL_LENGTH = 160;
    localparam int unsigned CLEAR_PASS_CYCLES = 1100;
    localparam int unsigned MAX_POS = (1 << POS_W) - 1;

    typedef struct {
        logic [CMD_W-1:0]      command;
        logic [VALUE_BITS-1:0] element_value;
        logic [POS_W-1:0]      prefix_end;
        logic [POS_W-1:0]      suffix_start;
    } t_engine_item;

    typedef struct {
        logic [CNT_W-1:0] distinct_count;
        logic             bad_query;
    } t_window_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wdc_in_if  in_ch ();
    wdc_out_if out_ch ();
    wdc_cfg_if cfg_ch ();

    window_distinct_count_engine uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #6 i_clk = ~i_clk;

    // Window tally that mirrors the engine.
    logic [VALUE_BITS-1:0] seq_values [MAX_LENGTH];
    int unsigned           value_tally [VALUE_DEPTH];
    int unsigned           win_first;
    int unsigned           win_last;
    int unsigned           distinct_now;
    int unsigned           next_slot;
    int unsigned           length_reg;
    t_window_answer        answers_due [$];

    // Item source state.
    t_engine_item          command_queue [$];
    int unsigned           gen_len;
    int unsigned           gen_ptr;
    int unsigned           gen_filled;
    int unsigned           items_queued;
    int unsigned           ignored_queued;
    int unsigned           queries_queued;
    bit                    last_was_query;
    bit                    quiet_tail;

    // Channel activity.
    t_engine_item          in_item;
    t_engine_item          taken_item;
    t_window_answer        checked_answer;
    bit                    in_taken;
    int unsigned           in_gap;
    int unsigned           out_stall;
    bit                    long_hold_done;
    int unsigned           items_taken;
    int unsigned           answers_checked;
    bit                    failed;

    function automatic void empty_tally();
        foreach (value_tally[v]) value_tally[v] = 0;
        win_first = 1;
        win_last = 0;
        distinct_now = 0;
    endfunction

    function automatic logic [VALUE_BITS-1:0] slot_value(input int unsigned pos,
                                                         input int unsigned n);
        int unsigned idx;
        idx = pos - 1;
        if (idx >= n) idx -= n;
        return seq_values[idx];
    endfunction

    function automatic void admit_slot(input int unsigned pos, input int unsigned n);
        logic [VALUE_BITS-1:0] v;
        v = slot_value(pos, n);
        value_tally[v]++;
        if (value_tally[v] == 1) distinct_now++;
    endfunction

    function automatic void drop_slot(input int unsigned pos, input int unsigned n);
        logic [VALUE_BITS-1:0] v;
        v = slot_value(pos, n);
        if (value_tally[v] != 0) begin
            value_tally[v]--;
            if (value_tally[v] == 0) distinct_now--;
        end
    endfunction

    function automatic void tally_item(input t_engine_item item);
        int unsigned    n;
        int unsigned    lo;
        int unsigned    hi;
        t_window_answer answer;
        case (item.command)
            CMD_LOAD: begin
                empty_tally();
                if (next_slot < MAX_LENGTH) begin
                    seq_values[next_slot] = item.element_value;
                    next_slot++;
                end
            end
            CMD_CLEAR: begin
                empty_tally();
                next_slot = 0;
            end
            CMD_QUERY: begin
                n = (length_reg > MAX_LENGTH) ? MAX_LENGTH : length_reg;
                answer.distinct_count = '0;
                answer.bad_query = 1'b1;
                if (n != 0 && item.prefix_end != 0 && item.suffix_start <= n &&
                    item.prefix_end < item.suffix_start) begin
                    lo = item.suffix_start;
                    hi = item.prefix_end + n;
                    while (win_last < hi) begin
                        win_last++;
                        admit_slot(win_last, n);
                    end
                    while (win_first > lo) begin
                        win_first--;
                        admit_slot(win_first, n);
                    end
                    while (win_first < lo) begin
                        drop_slot(win_first, n);
                        win_first++;
                    end
                    while (win_last > hi) begin
                        drop_slot(win_last, n);
                        win_last--;
                    end
                    answer.distinct_count = distinct_now[CNT_W-1:0];
                    answer.bad_query = 1'b0;
                end
                answers_due.push_back(answer);
            end
            default: ;
        endcase
    endfunction

    function automatic int unsigned gen_eff();
        return (gen_len > MAX_LENGTH) ? MAX_LENGTH : gen_len;
    endfunction

    function automatic void push_item(input logic [CMD_W-1:0] cmd,
                                      input int unsigned value,
                                      input int unsigned pe,
                                      input int unsigned ss);
        t_engine_item item;
        item.command = cmd;
        item.element_value = VALUE_BITS'(value);
        item.prefix_end = POS_W'(pe);
        item.suffix_start = POS_W'(ss);
        command_queue.push_back(item);
        items_queued++;
        last_was_query = (cmd == CMD_QUERY);
        case (cmd)
            CMD_LOAD: begin
                if (gen_ptr < MAX_LENGTH) begin
                    gen_ptr++;
                    if (gen_ptr > gen_filled) gen_filled = gen_ptr;
                end else begin
                    ignored_queued++;
                end
            end
            CMD_QUERY: queries_queued++;
            CMD_CLEAR: gen_ptr = 0;
            default: ignored_queued++;
        endcase
    endfunction

    // A window query is only formed when every entry it may touch has been loaded.
    function automatic void push_random_query();
        int unsigned n;
        int unsigned pe;
        int unsigned ss;
        bit          ok;
        n = gen_eff();
        ok = (n >= 2 && gen_filled >= n);
        if (ok && $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
                0: begin
                    pe = 1;
                    ss = n;
                end
                1: begin
                    pe = n - 1;
                    ss = n;
                end
                default: begin
                    pe = $urandom_range(1, n - 1);
                    ss = $urandom_range(pe + 1, n);
                end
            endcase
        end else begin
            pe = $urandom_range(0, MAX_POS);
            ss = $urandom_range(0, MAX_POS);
            case ($urandom_range(0, 3))
                0: pe = 0;
                1: pe = ss;
                2: ss = $urandom_range(n + 1, MAX_POS);
                default: ;
            endcase
            if (!ok && pe != 0 && pe < ss && ss <= n) ss = 0;
        end
        push_item(CMD_QUERY, $urandom_range(0, VALUE_DEPTH - 1), pe, ss);
    endfunction

    task automatic write_seq_length(input int unsigned value);
        gen_len = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.seq_length <= POS_W'(value);
        forever begin
            @(posedge i_clk);
            if (cfg_ch.ready) break;
        end
        length_reg = value;
        empty_tally();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_for_idle();
        do @(negedge i_clk);
        while (items_taken != items_queued || answers_checked != queries_queued);
        repeat (last_was_query ? 4 : CLEAR_PASS_CYCLES) @(negedge i_clk);
    endtask

    // Item channel acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            in_taken = 1'b1;
            items_taken++;
            taken_item.command = in_ch.command;
            taken_item.element_value = in_ch.element_value;
            taken_item.prefix_end = in_ch.prefix_end;
            taken_item.suffix_start = in_ch.suffix_start;
            tally_item(taken_item);
        end
    end

    // Item channel driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            in_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (command_queue.size() != 0) begin
                in_item = command_queue.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.command <= in_item.command;
                in_ch.element_value <= in_item.element_value;
                in_ch.prefix_end <= in_item.prefix_end;
                in_ch.suffix_start <= in_item.suffix_start;
                if (!quiet_tail && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 3);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result channel monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            answers_checked++;
            if (!long_hold_done && answers_checked >= LONG_HOLD_AT &&
                answers_due.size() > 1 && command_queue.size() >= 3) begin
                out_stall = RESULT_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (answers_due.size() == 0) begin
                $error("result with none outstanding: distinct_count %0d bad_query %0b",
                       out_ch.distinct_count, out_ch.bad_query);
                failed = 1'b1;
            end else begin
                checked_answer = answers_due.pop_front();
                if (out_ch.distinct_count !== checked_answer.distinct_count) begin
                    $error("distinct_count: expected %0d, actual %0d",
                           checked_answer.distinct_count, out_ch.distinct_count);
                    failed = 1'b1;
                end
                if (out_ch.bad_query !== checked_answer.bad_query) begin
                    $error("bad_query: expected %0b, actual %0b",
                           checked_answer.bad_query, out_ch.bad_query);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 6) == 0) out_stall = $urandom_range(1, 3);
        end
    end

    initial begin
        int unsigned base;
        int unsigned eff;
        int unsigned pool;
        int unsigned r;

        in_ch.valid = 1'b0;
        in_ch.command = CMD_LOAD;
        in_ch.element_value = '0;
        in_ch.prefix_end = '0;
        in_ch.suffix_start = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.seq_length = POS_W'(1);

        foreach (seq_values[i]) seq_values[i] = '0;
        empty_tally();
        length_reg = 1;
        next_slot = 0;
        gen_len = 1;
        gen_ptr = 0;
        gen_filled = 0;
        items_queued = 0;
        ignored_queued = 0;
        queries_queued = 0;
        last_was_query = 1'b0;
        quiet_tail = 1'b0;
        in_taken = 1'b0;
        in_gap = 0;
        out_stall = 0;
        long_hold_done = 1'b0;
        items_taken = 0;
        answers_checked = 0;
        failed = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // With the reset length of one, no query can name a window.
        push_item(CMD_QUERY, 1023, 1, 1);
        push_item(CMD_QUERY, 0, 0, 1);
        push_item(CMD_QUERY, 0, MAX_POS, MAX_POS);
        push_item(CMD_UNUSED, 1023, MAX_POS, MAX_POS);
        push_item(CMD_LOAD, 0, 0, 0);
        push_item(CMD_LOAD, 1023, MAX_POS, MAX_POS);
        push_item(CMD_LOAD, 5, 0, 0);
        push_item(CMD_LOAD, 1023, 0, 0);
        push_item(CMD_LOAD, 5, 0, 0);
        push_item(CMD_CLEAR, 0, 0, 0);
        push_item(CMD_LOAD, 7, 0, 0);
        push_item(CMD_QUERY, 0, 1, 2);
        wait_for_idle();

        write_seq_length(4);
        @(posedge i_clk);
        push_item(CMD_QUERY, 0, 1, 2);
        push_item(CMD_QUERY, 0, 3, 4);
        push_item(CMD_QUERY, 0, 1, 4);
        push_item(CMD_QUERY, 0, 2, 3);
        push_item(CMD_QUERY, 0, 0, 3);
        push_item(CMD_QUERY, 0, 3, 3);
        push_item(CMD_QUERY, 0, 4, 2);
        push_item(CMD_QUERY, 0, 1, 5);
        push_item(CMD_LOAD, 0, 0, 0);
        push_item(CMD_QUERY, 0, 2, 3);
        wait_for_idle();

        write_seq_length(3);
        @(posedge i_clk);
        push_item(CMD_QUERY, 0, 1, 2);
        wait_for_idle();

        // Load a long run of distinct values.
        @(posedge i_clk);
        push_item(CMD_CLEAR, 0, 0, 0);
        for (int i = 0; i < FILL_LENGTH; i++) begin
            push_item(CMD_LOAD, i, 0, 0);
        end
        push_item(CMD_QUERY, 0, 1, 3);
        wait_for_idle();

        write_seq_length(FILL_LENGTH);
        @(posedge i_clk);
        push_item(CMD_QUERY, 0, FILL_LENGTH - 1, FILL_LENGTH);
        push_item(CMD_QUERY, 0, 1, FILL_LENGTH);
        push_item(CMD_QUERY, 0, FILL_LENGTH / 2, FILL_LENGTH / 2 + 1);
        push_item(CMD_QUERY, 0, 0, 5);
        push_item(CMD_QUERY, 0, FILL_LENGTH, FILL_LENGTH);
        push_item(CMD_QUERY, 0, 5, FILL_LENGTH + 1);
        push_item(CMD_QUERY, 0, 1, 2);
        wait_for_idle();

        // A length above the store size is used as the store size.
        write_seq_length(MAX_POS);
        @(posedge i_clk);
        push_item(CMD_QUERY, 0, MAX_LENGTH, MAX_LENGTH);
        push_item(CMD_QUERY, 0, 5, MAX_LENGTH + 1);
        push_item(CMD_QUERY, 0, 0, 3);
        wait_for_idle();

        write_seq_length(0);
        @(posedge i_clk);
        push_item(CMD_QUERY, 0, 1, 2);
        push_item(CMD_QUERY, 0, 0, 0);

        base = items_queued - ignored_queued;
        while (items_queued - ignored_queued - base < RANDOM_ITEMS) begin
            wait_for_idle();
            case ($urandom_range(0, 19))
                0: write_seq_length(0);
                1: write_seq_length(1);
                2: write_seq_length($urandom_range(0, 1) ? MAX_LENGTH : MAX_POS);
                3: write_seq_length($urandom_range(25, 300));
                default: write_seq_length($urandom_range(2, 24));
            endcase
            @(posedge i_clk);
            quiet_tail = (items_queued - ignored_queued - base >= RANDOM_ITEMS - 80);
            eff = gen_eff();
            case ($urandom_range(0, 4))
                0: pool = 0;
                1: pool = 1;
                2: pool = 3;
                3: pool = 15;
                default: pool = VALUE_DEPTH - 1;
            endcase
            if (eff <= 300 && $urandom_range(0, 2) != 0) begin
                push_item(CMD_CLEAR, $urandom_range(0, VALUE_DEPTH - 1),
                          $urandom_range(0, MAX_POS), $urandom_range(0, MAX_POS));
                repeat ($urandom_range(1, (eff < 30) ? eff + 2 : 32)) begin
                    push_item(CMD_LOAD, $urandom_range(0, pool),
                              $urandom_range(0, MAX_POS), $urandom_range(0, MAX_POS));
                end
            end
            repeat ((eff > 300) ? 2 : $urandom_range(6, 20)) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    push_random_query();
                end else if (r < 82) begin
                    push_item(CMD_LOAD, $urandom_range(0, pool),
                              $urandom_range(0, MAX_POS), $urandom_range(0, MAX_POS));
                end else if (r < 88) begin
                    push_item(CMD_CLEAR, $urandom_range(0, VALUE_DEPTH - 1),
                              $urandom_range(0, MAX_POS), $urandom_range(0, MAX_POS));
                end else begin
                    push_item(CMD_UNUSED, $urandom_range(0, VALUE_DEPTH - 1),
                              $urandom_range(0, MAX_POS), $urandom_range(0, MAX_POS));
                end
            end
            push_random_query();
        end

        wait_for_idle();
        repeat (CLEAR_PASS_CYCLES) @(negedge i_clk);
        if (answers_due.size() != 0) begin
            $error("%0d expected results never arrived", answers_due.size());
            failed = 1'b1;
        end
        if (failed) begin
            $display("status: fail");
        end else begin
            $display("status: pass");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== window_distinct_count_engine.f =====
rtl/core/wdc_pkg.sv
rtl/core/wdc_if.sv
rtl/core/wdc_ctrl.sv
rtl/core/wdc_datapath.sv
rtl/core/window_distinct_count_engine.sv
tb/sv/tb_window_distinct_count_engine.sv
